// File: sv/gxb_pkg.sv
// Package: op codes, word types and fixed widths for the GF(2) basis reducer.
`default_nettype none

package gxb_pkg;

    // Fixed field widths of the input and result words
    localparam int HALF_BITS = 36;
    localparam int IN_BITS   = 72;

    // Op codes
    localparam logic [1:0] OP_REDUCE = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Input word
    typedef struct packed {
        logic [1:0]           op;
        logic [HALF_BITS-1:0] low_half;
        logic [HALF_BITS-1:0] high_half;
    } t_in;

    // Result word
    typedef struct packed {
        logic [HALF_BITS-1:0] reduced_low;
        logic [HALF_BITS-1:0] reduced_high;
        logic                 in_span;
        logic                 inserted;
    } t_res;

    // Control that travels down the cell chain next to the vector
    typedef struct packed {
        logic vld;      // a vector sits in this stage
        logic ins;      // the word is an insert
        logic claimed;  // a higher cell already took the leading bit
    } t_ctl;

endpackage

`default_nettype wire

// File: sv/gxb_cell.sv
// One pivot cell: holds the basis vector whose leading bit is POS.
`default_nettype none

module gxb_cell #(
    parameter int VB  = 72,
    parameter int POS = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire gxb_pkg::t_ctl i_ctl,
    input  wire logic [VB-1:0] i_vec,
    input  wire logic          i_clear,
    input  wire logic          i_commit,
    input  wire logic [VB-1:0] i_wr_vec,
    output gxb_pkg::t_ctl      o_ctl,
    output logic [VB-1:0]      o_vec
);

    logic          r_has;
    logic          r_pend;
    logic [VB-1:0] r_piv;
    gxb_pkg::t_ctl r_ctl;
    logic [VB-1:0] r_vec;

    logic          hit;
    logic          claim_here;
    gxb_pkg::t_ctl n_ctl;
    logic [VB-1:0] n_vec;

    // Reduce by the stored pivot, or mark this position as the new leading bit
    always_comb begin
        hit        = i_vec[POS] && r_has;
        claim_here = i_ctl.vld && i_ctl.ins && i_vec[POS] && !r_has && !i_ctl.claimed;
        n_vec      = hit ? (i_vec ^ r_piv) : i_vec;
        n_ctl      = i_ctl;
        n_ctl.claimed = i_ctl.claimed || claim_here;
    end

    // Pipeline stage toward the next lower cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
        r_vec <= n_vec;
    end

    // Pivot storage: written once the fully reduced vector leaves the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has  <= 1'b0;
            r_pend <= 1'b0;
        end else if (i_clear) begin
            r_has  <= 1'b0;
            r_pend <= 1'b0;
        end else if (i_commit) begin
            if (r_pend) begin
                r_has <= 1'b1;
            end
            r_pend <= 1'b0;
        end else if (claim_here) begin
            r_pend <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit && r_pend) begin
            r_piv <= i_wr_vec;
        end
    end

    assign o_ctl = r_ctl;
    assign o_vec = r_vec;

endmodule

`default_nettype wire

// File: sv/gf2_xor_basis_reducer.sv
// Top level: GF(2) XOR basis reducer built as a chain of pivot cells.
//
//  channel  | ports                     | handshake
//  ---------+---------------------------+-------------------------------------
//  input    | start, busy, i_item       | word taken when start && !busy
//  result   | o_done, o_result          | one-cycle strobe, cannot be stalled
//
// A reduce or insert word walks the VECTOR_BITS cells from the top position
// down, one cell per cycle; busy is high from the accept edge until the
// vector leaves the last cell, and o_done is registered from that exit, so
// the next word can be taken in the o_done cycle. A new pivot is written at
// the edge the vector leaves the last cell. A clear word empties all cells at
// its accept edge and returns its result the next cycle without raising busy.
// Synchronous active-low reset empties the basis; no clearing pass is needed.
`default_nettype none

module gf2_xor_basis_reducer #(
    parameter int VECTOR_BITS = 72
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire gxb_pkg::t_in   i_item,
    output logic                busy,
    output logic                o_done,
    output gxb_pkg::t_res       o_result
);

    localparam int VB = VECTOR_BITS;
    localparam int IB = gxb_pkg::IN_BITS;
    localparam int HB = gxb_pkg::HALF_BITS;

    logic                accept;
    logic                clr_now;
    logic [IB-1:0]       in_full;
    logic [VB-1:0]       in_vec;
    logic [IB-1:0]       out_full;
    logic                commit;

    gxb_pkg::t_ctl       ctl_chain [VB:0];
    logic [VB-1:0]       vec_chain [VB:0];

    logic                r_busy;
    logic                r_done;
    gxb_pkg::t_res       r_res;
    gxb_pkg::t_res       n_res;

    assign accept  = start && !r_busy;
    assign clr_now = accept && (i_item.op == gxb_pkg::OP_CLEAR);
    assign in_full = {i_item.high_half, i_item.low_half};

    // Fit the 72-bit input word to the basis width
    for (genvar g = 0; g < VB; g++) begin : g_in
        if (g < IB) begin : g_keep
            assign in_vec[g] = in_full[g];
        end else begin : g_zero
            assign in_vec[g] = 1'b0;
        end
    end

    // Chain entry
    always_comb begin
        ctl_chain[VB].vld     = accept && (i_item.op != gxb_pkg::OP_CLEAR);
        ctl_chain[VB].ins     = (i_item.op == gxb_pkg::OP_INSERT);
        ctl_chain[VB].claimed = 1'b0;
        vec_chain[VB]         = in_vec;
    end

    assign commit = ctl_chain[0].vld && ctl_chain[0].claimed;

    // Pivot cells, highest position first
    for (genvar g = 0; g < VB; g++) begin : g_cell
        gxb_cell #(
            .VB  (VB),
            .POS (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl_chain[g+1]),
            .i_vec    (vec_chain[g+1]),
            .i_clear  (clr_now),
            .i_commit (commit),
            .i_wr_vec (vec_chain[0]),
            .o_ctl    (ctl_chain[g]),
            .o_vec    (vec_chain[g])
        );
    end

    // Map the reduced vector back onto 72 result bits
    for (genvar g = 0; g < IB; g++) begin : g_out
        if (g < VB) begin : g_keep
            assign out_full[g] = vec_chain[0][g];
        end else begin : g_zero
            assign out_full[g] = 1'b0;
        end
    end

    // Result word
    always_comb begin
        n_res              = '0;
        n_res.reduced_low  = out_full[HB-1:0];
        n_res.reduced_high = out_full[IB-1:HB];
        n_res.in_span      = (vec_chain[0] == '0);
        n_res.inserted     = ctl_chain[0].claimed;
    end

    // Busy and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (ctl_chain[VB].vld) begin
                r_busy <= 1'b1;
            end else if (ctl_chain[0].vld) begin
                r_busy <= 1'b0;
            end
            r_done <= ctl_chain[0].vld || clr_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (clr_now) begin
            r_res <= '0;
        end else if (ctl_chain[0].vld) begin
            r_res <= n_res;
        end
    end

    assign busy     = r_busy;
    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef ASSERT_OFF
    // A result only follows a word in flight or a clear
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy || clr_now))
        else $error("result strobe without a word in flight");

    // A committed pivot is reported as inserted and out of span
    a_commit_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (o_done && o_result.inserted && !o_result.in_span))
        else $error("pivot commit not reflected in result");

    // Inserted and in-span exclude each other
    a_span_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.in_span) |-> !o_result.inserted)
        else $error("inserted vector reported in span");

    // A reduce or insert word raises busy
    a_busy_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !clr_now) |=> busy)
        else $error("busy not raised after accept");

    // Only one vector travels the chain while busy drops at its exit
    a_exit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_chain[0].vld |=> !busy)
        else $error("busy still high after the vector left the chain");
`endif

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for the GF(2) XOR basis reducer: queued driver, result monitor, predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          VB          = 72;
    localparam int          IN_BITS     = gxb_pkg::IN_BITS;
    localparam int          HALF_BITS   = gxb_pkg::HALF_BITS;
    localparam logic [1:0]  OP_SPARE    = 2'd3;   // unused code, behaves as reduce
    localparam int          WORD_TARGET = 1920;
    localparam int          WATCH_LIMIT = 2000;

    // One queued input word plus its pacing
    typedef struct {
        gxb_pkg::t_in w;
        int unsigned  gap;     // idle cycles after the previous accept
        bit           drain;   // hold until every result is back
    } t_pend_word;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start   = 1'b0;
    gxb_pkg::t_in  i_item  = '0;
    logic          busy;
    logic          o_done;
    gxb_pkg::t_res o_result;

    t_pend_word          pending_words[$];
    gxb_pkg::t_res       expected_results[$];
    logic [VB-1:0]       pivots[VB];
    logic [IN_BITS-1:0]  gen_pool[$];
    int unsigned         gap_left     = 0;
    int unsigned         words_taken  = 0;
    int unsigned         mismatch_cnt = 0;
    int unsigned         idle_cycles  = 0;

    gf2_xor_basis_reducer #(.VECTOR_BITS(VB)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        foreach (pivots[p]) pivots[p] = '0;
    end

    // Predictor: reduce against the pivot store, insert or clear as the op says
    function automatic gxb_pkg::t_res basis_apply(gxb_pkg::t_in w);
        logic [VB-1:0]      v;
        logic [IN_BITS-1:0] wide;
        gxb_pkg::t_res      r;
        r = '0;
        if (w.op == gxb_pkg::OP_CLEAR) begin
            foreach (pivots[p]) pivots[p] = '0;
            return r;
        end
        v = VB'({w.high_half, w.low_half});
        for (int p = VB - 1; p >= 0; p--) begin
            if (v[p] && pivots[p] != '0) v ^= pivots[p];
        end
        if (w.op == gxb_pkg::OP_INSERT && v != '0) begin
            for (int p = VB - 1; p >= 0; p--) begin
                if (v[p]) begin
                    pivots[p] = v;
                    break;
                end
            end
            r.inserted = 1'b1;
        end
        wide           = IN_BITS'(v);
        r.reduced_low  = wide[HALF_BITS-1:0];
        r.reduced_high = wide[IN_BITS-1:HALF_BITS];
        r.in_span      = (v == '0);
        return r;
    endfunction

    function automatic logic [IN_BITS-1:0] rand_vec();
        return IN_BITS'({$urandom(), $urandom(), $urandom()});
    endfunction

    // XOR of a random subset of the insert vectors queued since the last clear
    function automatic logic [IN_BITS-1:0] span_combo();
        logic [IN_BITS-1:0] acc;
        acc = '0;
        foreach (gen_pool[k]) begin
            if ($urandom_range(1, 0) == 1) acc ^= gen_pool[k];
        end
        return acc;
    endfunction

    // Mostly short gaps, a few long ones that land in any phase of the busy window
    function automatic int unsigned pick_gap(bit burst);
        int unsigned r;
        if (burst) return 0;
        r = $urandom_range(99, 0);
        if (r < 45) return 0;
        if (r < 70) return $urandom_range(3, 1);
        if (r < 90) return $urandom_range(80, 4);
        return $urandom_range(150, 81);
    endfunction

    task automatic add_word(logic [1:0] op, logic [IN_BITS-1:0] vec, int unsigned gap,
                            bit drain);
        t_pend_word pw;
        pw.w.op        = op;
        pw.w.low_half  = vec[HALF_BITS-1:0];
        pw.w.high_half = vec[IN_BITS-1:HALF_BITS];
        pw.gap         = gap;
        pw.drain       = drain;
        pending_words  = {pending_words, pw};
        if (op == gxb_pkg::OP_CLEAR) gen_pool.delete();
        else if (op == gxb_pkg::OP_INSERT) gen_pool = {gen_pool, vec};
    endtask

    // Word list: directed corners first, then random basis-building sequences
    initial begin
        bit                  burst;
        bit                  drain;
        int unsigned         n_ins;
        int unsigned         n_red;
        int unsigned         sel;
        int unsigned         w;
        logic [IN_BITS-1:0]  mask;
        logic [IN_BITS-1:0]  vec;
        logic [1:0]          op;

        add_word(gxb_pkg::OP_REDUCE, '0, 0, 1'b0);
        add_word(gxb_pkg::OP_REDUCE, '1, 0, 1'b0);
        add_word(gxb_pkg::OP_INSERT, '1, 2, 1'b0);
        add_word(gxb_pkg::OP_INSERT, '1, 0, 1'b0);               // already in span
        add_word(gxb_pkg::OP_INSERT, '0, 0, 1'b0);               // zero vector
        add_word(gxb_pkg::OP_INSERT, 72'h1, 0, 1'b0);
        add_word(gxb_pkg::OP_INSERT, 72'h1 << 35, 1, 1'b0);      // top of low half
        add_word(gxb_pkg::OP_INSERT, 72'h1 << 36, 0, 1'b0);      // bottom of high half
        add_word(gxb_pkg::OP_INSERT, {36'hFFFFFFFFF, 36'h0}, 0, 1'b0);
        add_word(gxb_pkg::OP_INSERT, {36'h0, 36'hFFFFFFFFF}, 5, 1'b0);
        add_word(gxb_pkg::OP_REDUCE, '1, 0, 1'b0);
        add_word(OP_SPARE, '1, 0, 1'b0);
        add_word(OP_SPARE, 72'hAAAAAAAAAAAAAAAAAA, 0, 1'b0);
        add_word(gxb_pkg::OP_INSERT, 72'h555555555555555555, 0, 1'b0);
        add_word(gxb_pkg::OP_REDUCE, 72'hAAAAAAAAAAAAAAAAAA, 0, 1'b1);
        add_word(gxb_pkg::OP_CLEAR, '1, 0, 1'b0);
        add_word(gxb_pkg::OP_REDUCE, '1, 0, 1'b0);
        add_word(gxb_pkg::OP_CLEAR, '0, 0, 1'b0);
        add_word(gxb_pkg::OP_CLEAR, 72'h123456789ABCDEF012, 0, 1'b0);
        add_word(gxb_pkg::OP_INSERT, 72'h1 << 71, 0, 1'b0);
        add_word(OP_SPARE, '0, 0, 1'b0);
        add_word(gxb_pkg::OP_CLEAR, '0, 3, 1'b0);

        while (pending_words.size() < WORD_TARGET) begin
            burst = ($urandom_range(9, 0) < 3);
            drain = ($urandom_range(19, 0) == 0);
            if ($urandom_range(2, 0) == 0) begin
                add_word(gxb_pkg::OP_CLEAR, rand_vec(), pick_gap(burst), drain);
                drain = 1'b0;
            end
            // subspace that this sequence draws from
            sel = $urandom_range(9, 0);
            if (sel < 4) begin
                mask = '1;
            end else if (sel < 7) begin
                mask = rand_vec() & rand_vec();
            end else begin
                w    = $urandom_range(20, 4);
                mask = ((IN_BITS'(1) << w) - 1) << $urandom_range(IN_BITS - w, 0);
            end
            n_ins = ($urandom_range(7, 0) == 0) ? $urandom_range(90, 72)
                                                : $urandom_range(24, 1);
            for (int k = 0; k < n_ins; k++) begin
                sel = $urandom_range(9, 0);
                if (sel < 7) vec = rand_vec() & mask;
                else if (sel < 9) vec = span_combo();
                else vec = IN_BITS'(1) << $urandom_range(IN_BITS - 1, 0);
                add_word(gxb_pkg::OP_INSERT, vec, pick_gap(burst), drain);
                drain = 1'b0;
            end
            n_red = $urandom_range(12, 1);
            for (int k = 0; k < n_red; k++) begin
                op  = ($urandom_range(3, 0) == 0) ? OP_SPARE : gxb_pkg::OP_REDUCE;
                vec = ($urandom_range(1, 0) == 1) ? span_combo() : (rand_vec() & mask);
                add_word(op, vec, pick_gap(burst), 1'b0);
            end
            // noise: any op code, dense payload
            if ($urandom_range(4, 0) == 0) begin
                n_red = $urandom_range(3, 1);
                for (int k = 0; k < n_red; k++) begin
                    add_word(2'($urandom_range(3, 0)), rand_vec(), pick_gap(burst), 1'b0);
                end
            end
        end
    end

    // Driver: offers the next queued word, predicts each accepted one
    always @(posedge i_clk) begin : drive
        logic         take;
        logic         nxt_start;
        gxb_pkg::t_in nxt_item;
        t_pend_word   pw;
        take      = start && !busy;
        nxt_start = start && !take;
        nxt_item  = i_item;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
        end else begin
            if (take) begin
                expected_results = {expected_results, basis_apply(i_item)};
                words_taken++;
                gap_left = (pending_words.size() != 0) ? pending_words[0].gap : 0;
            end
            if (!nxt_start && pending_words.size() != 0) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (!(pending_words[0].drain && expected_results.size() != 0)) begin
                    pw        = pending_words.pop_front();
                    nxt_item  = pw.w;
                    nxt_start = 1'b1;
                end
            end
        end
        start  <= nxt_start;
        i_item <= nxt_item;
    end

    // Monitor: every strobed result against the oldest prediction
    always @(posedge i_clk) begin : watch_results
        gxb_pkg::t_res want;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected: %0h", o_result);
                mismatch_cnt++;
            end else begin
                want = expected_results.pop_front();
                if (o_result.reduced_low !== want.reduced_low) begin
                    $error("reduced_low: expected %0h, got %0h",
                           want.reduced_low, o_result.reduced_low);
                    mismatch_cnt++;
                end
                if (o_result.reduced_high !== want.reduced_high) begin
                    $error("reduced_high: expected %0h, got %0h",
                           want.reduced_high, o_result.reduced_high);
                    mismatch_cnt++;
                end
                if (o_result.in_span !== want.in_span) begin
                    $error("in_span: expected %0b, got %0b", want.in_span, o_result.in_span);
                    mismatch_cnt++;
                end
                if (o_result.inserted !== want.inserted) begin
                    $error("inserted: expected %0b, got %0b", want.inserted, o_result.inserted);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Watchdog: too long without any accepted word in either direction
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCH_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // End of run: all words taken, all results back, then a latency tail
    initial begin
        @(posedge i_clk);
        while (pending_words.size() != 0 || start || words_taken == 0
               || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (VB + 8) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_results.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
